### sv/sobel_pkg.sv
package sobel_pkg;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_LOAD,
    ST_CALC,
    ST_OUT
  } sobel_state_e;

  typedef struct packed {
    logic take;
    logic load;
    logic calc;
    logic emit;
  } sobel_cmd_t;

  typedef struct packed {
    logic has_result;
    logic calc_done;
  } sobel_sts_t;

  localparam logic [10:0] WidthReset  = 11'd640;
  localparam logic [12:0] HeightReset = 13'd480;
  localparam logic        RegWidth    = 1'b0;
  localparam logic        RegHeight   = 1'b1;

endpackage

### sv/sobel_edge_magnitude_rgb.sv
// Sobel edge magnitude on a raster RGB stream.
// Input channel: in_valid_i / in_stall_o carry kind_i and the pixel fields.
// Output channel: out_valid_o / out_stall_i carry the three magnitudes and
// frame_done_o, which marks the last pixel of a frame.
// Configuration: cfg_we_i with cfg_idx_i (0 width, 1 height) and cfg_data_i;
// a write restarts the frame. Write only while idle.
// An item that yields no result is accepted and loaded into the window. An item
// that yields a result passes accept, window load, the magnitude unit
// (squared sum, one root candidate per cycle for r = 1..255, done), and the
// output state; out_valid_o rises once the magnitude unit is done.
// Output (i,j) follows input item i*W+j+W+1; feed W+1 drain items after the
// last pixel to flush the frame.
// Reset: width 640, height 480, counters and window cleared; line stores
// need no clearing.
// While out_stall_i is high, the result holds and no input is accepted.
module sobel_edge_magnitude_rgb
  import sobel_pkg::*;
#(
  parameter int MaxWidth  = 1024,
  parameter int MaxHeight = 4096
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [0:0]  cfg_idx_i,
  input  logic [12:0] cfg_data_i,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic        kind_i,
  input  logic [7:0]  red_in_i,
  input  logic [7:0]  green_in_i,
  input  logic [7:0]  blue_in_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [7:0]  red_out_o,
  output logic [7:0]  green_out_o,
  output logic [7:0]  blue_out_o,
  output logic        frame_done_o
);

  sobel_cmd_t cmd;
  sobel_sts_t sts;

  sobel_ctrl u_ctrl (
    .clk_i, .rst_ni, .in_valid_i, .in_stall_o, .out_valid_o, .out_stall_i,
    .sts_i(sts), .cmd_o(cmd)
  );

  sobel_dp #(.MaxWidth(MaxWidth), .MaxHeight(MaxHeight)) u_dp (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_idx_i, .cfg_data_i,
    .cmd_i(cmd), .sts_o(sts),
    .kind_i, .red_in_i, .green_in_i, .blue_in_i,
    .red_out_o, .green_out_o, .blue_out_o, .frame_done_o
  );

`ifndef SYNTH
  a_no_overlap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> in_stall_o) else $error("input taken during output");
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(red_out_o))
    else $error("stalled result changed");
`endif

endmodule

### sv/sobel_ctrl.sv
module sobel_ctrl
  import sobel_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_stall_o,
  output logic       out_valid_o,
  input  logic       out_stall_i,
  input  sobel_sts_t sts_i,
  output sobel_cmd_t cmd_o
);

  sobel_state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: if (in_valid_i) state_d = ST_LOAD;
      ST_LOAD: state_d = sts_i.has_result ? ST_CALC : ST_IDLE;
      ST_CALC: if (sts_i.calc_done) state_d = ST_OUT;
      ST_OUT:  if (!out_stall_i) state_d = ST_IDLE;
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd_o       = '0;
    in_stall_o  = 1'b1;
    out_valid_o = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        in_stall_o = 1'b0;
        cmd_o.take = in_valid_i;
      end
      ST_LOAD: cmd_o.load = 1'b1;
      ST_CALC: cmd_o.calc = 1'b1;
      ST_OUT: begin
        out_valid_o = 1'b1;
        cmd_o.emit  = !out_stall_i;
      end
      default: ;
    endcase
  end

endmodule

### sv/sobel_dp.sv
module sobel_dp
  import sobel_pkg::*;
#(
  parameter int MaxWidth  = 1024,
  parameter int MaxHeight = 4096
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [0:0]  cfg_idx_i,
  input  logic [12:0] cfg_data_i,
  input  sobel_cmd_t  cmd_i,
  output sobel_sts_t  sts_o,
  input  logic        kind_i,
  input  logic [7:0]  red_in_i,
  input  logic [7:0]  green_in_i,
  input  logic [7:0]  blue_in_i,
  output logic [7:0]  red_out_o,
  output logic [7:0]  green_out_o,
  output logic [7:0]  blue_out_o,
  output logic        frame_done_o
);

  localparam int AW = (MaxWidth > 1) ? $clog2(MaxWidth) : 1;
  localparam int CW = 23;
  localparam int ResetTotal = ((MaxWidth < 640) ? MaxWidth : 640) *
                              ((MaxHeight < 480) ? MaxHeight : 480);

  logic [10:0] width_q;
  logic [12:0] height_q;
  logic [23:0] older_mem [MaxWidth];
  logic [23:0] newer_mem [MaxWidth];
  logic [23:0] win_q [3][3];
  logic [CW-1:0] n_q, total_q;
  logic [AW-1:0] col_q;
  logic [23:0] pix_q, older_q, newer_q;
  logic [CW-1:0] ew, eh, tot_d;
  logic [AW:0]  j_q;
  logic [16:0]  i_q;
  logic         res_q, done_q;
  logic [8:0]   r_q;
  logic [21:0]  s_q [3];
  logic [21:0]  sq [3];
  logic [7:0]   mag_q [3];

  always_comb begin
    ew = (width_q == 0) ? CW'(1) :
         (32'(width_q) > MaxWidth) ? CW'(MaxWidth) : CW'(width_q);
    eh = (height_q == 0) ? CW'(1) :
         (32'(height_q) > MaxHeight) ? CW'(MaxHeight) : CW'(height_q);
    tot_d = CW'(ew * eh);
  end

  logic frame_end;
  assign frame_end = cmd_i.emit && done_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.take) begin
      older_q <= older_mem[col_q];
      newer_q <= newer_mem[col_q];
      older_mem[col_q] <= newer_mem[col_q];
      newer_mem[col_q] <= (!kind_i && n_q < total_q) ?
                          {red_in_i, green_in_i, blue_in_i} : 24'd0;
      pix_q <= (!kind_i && n_q < total_q) ? {red_in_i, green_in_i, blue_in_i} : 24'd0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q  <= WidthReset;
      height_q <= HeightReset;
      n_q <= '0; col_q <= '0; j_q <= '0; i_q <= '0;
      res_q <= 1'b0; done_q <= 1'b0; total_q <= CW'(ResetTotal);
      for (int a = 0; a < 3; a++) for (int b = 0; b < 3; b++) win_q[a][b] <= '0;
    end else begin
      total_q <= tot_d;
      if (cfg_we_i || frame_end) begin
        if (cfg_we_i && cfg_idx_i == RegWidth)  width_q  <= cfg_data_i[10:0];
        if (cfg_we_i && cfg_idx_i == RegHeight) height_q <= cfg_data_i;
        n_q <= '0; col_q <= '0; j_q <= '0; i_q <= '0;
        for (int a = 0; a < 3; a++) for (int b = 0; b < 3; b++) win_q[a][b] <= '0;
      end else begin
        if (cmd_i.take) begin
          n_q   <= n_q + 1'b1;
          col_q <= (CW'(col_q) + 1 == ew) ? '0 : col_q + 1'b1;
          res_q <= (n_q >= ew + 1) && (n_q - ew - 1 < total_q);
          done_q <= (n_q - ew - 1 == total_q - 1);
        end
        if (cmd_i.load) begin
          for (int a = 0; a < 3; a++) begin
            win_q[a][0] <= win_q[a][1];
            win_q[a][1] <= win_q[a][2];
          end
          win_q[0][2] <= older_q;
          win_q[1][2] <= newer_q;
          win_q[2][2] <= pix_q;
        end
        if (cmd_i.emit) begin
          if (CW'(j_q) + 1 == ew) begin
            j_q <= '0;
            i_q <= i_q + 1'b1;
          end else begin
            j_q <= j_q + 1'b1;
          end
        end
      end
    end
  end

  // gradient: 3x3 window, per channel, masked at frame border
  logic signed [11:0] gx [3], gy [3];
  always_comb begin
    logic [7:0] v;
    logic ok_r, ok_c;
    for (int ch = 0; ch < 3; ch++) begin
      gx[ch] = '0;
      gy[ch] = '0;
      for (int a = 0; a < 3; a++) begin
        for (int b = 0; b < 3; b++) begin
          ok_r = !((a == 0 && i_q == 0) || (a == 2 && CW'(i_q) + 1 >= eh));
          ok_c = !((b == 0 && j_q == 0) || (b == 2 && CW'(j_q) + 1 >= ew));
          v = (ok_r && ok_c) ? win_q[a][b][16-8*ch +: 8] : 8'd0;
          if (b == 0) gx[ch] = gx[ch] - (a == 1 ? 12'(v) <<< 1 : 12'(v));
          if (b == 2) gx[ch] = gx[ch] + (a == 1 ? 12'(v) <<< 1 : 12'(v));
          if (a == 0) gy[ch] = gy[ch] - (b == 1 ? 12'(v) <<< 1 : 12'(v));
          if (a == 2) gy[ch] = gy[ch] + (b == 1 ? 12'(v) <<< 1 : 12'(v));
        end
      end
      sq[ch] = $unsigned(22'(gx[ch]) * 22'(gx[ch]) + 22'(gy[ch]) * 22'(gy[ch]));
    end
  end

  // root search: one candidate per cycle
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      r_q <= '0;
    end else if (cmd_i.load) begin
      r_q <= 9'd1;
    end else if (cmd_i.calc && r_q <= 9'd256) begin
      r_q <= r_q + 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      for (int ch = 0; ch < 3; ch++) mag_q[ch] <= '0;
    end else if (r_q == 9'd1 && cmd_i.calc) begin
      for (int ch = 0; ch < 3; ch++) begin
        s_q[ch] <= sq[ch];
      end
    end else if (cmd_i.calc && r_q <= 9'd256) begin
      for (int ch = 0; ch < 3; ch++) begin
        if ((22'(r_q) - 22'd1) * (22'(r_q) - 22'd2) < s_q[ch]) mag_q[ch] <= mag_q[ch] + 1'b1;
      end
    end
  end

  assign sts_o.has_result = res_q;
  assign sts_o.calc_done  = (r_q == 9'd257);
  assign red_out_o    = mag_q[0];
  assign green_out_o  = mag_q[1];
  assign blue_out_o   = mag_q[2];
  assign frame_done_o = done_q;

endmodule

### tb/sv/tb_top.sv
module tb_top;
  import sobel_pkg::*;

  localparam int MaxW = 1024;
  localparam int MaxH = 4096;
  localparam int CycleLimit = 4000000;

  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic       done;
  } edge_pixel_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        cfg_we_i = 1'b0;
  logic [0:0]  cfg_idx_i = RegWidth;
  logic [12:0] cfg_data_i = '0;
  logic        in_valid_i = 1'b0;
  logic        in_stall_o;
  logic        kind_i = 1'b0;
  logic [7:0]  red_in_i = '0;
  logic [7:0]  green_in_i = '0;
  logic [7:0]  blue_in_i = '0;
  logic        out_valid_o;
  logic        out_stall_i = 1'b0;
  logic [7:0]  red_out_o;
  logic [7:0]  green_out_o;
  logic [7:0]  blue_out_o;
  logic        frame_done_o;

  sobel_edge_magnitude_rgb DUT (.*);

  always #5 clk_i = ~clk_i;

  // predictor state
  logic [10:0] width_reg = WidthReset;
  logic [12:0] height_reg = HeightReset;
  logic [23:0] row_older [MaxW];
  logic [23:0] row_newer [MaxW];
  logic [23:0] win [3][3];
  int unsigned pixels_seen;
  edge_pixel_t expected_pixels[$];

  int  failures = 0;
  int  items_sent = 0;
  int  burst_left = 0;
  bit  gaps_on = 1'b1;
  int  cycles = 0;

  function automatic int unsigned active_width();
    if (width_reg < 1) return 1;
    if (width_reg > MaxW) return MaxW;
    return width_reg;
  endfunction

  function automatic int unsigned active_height();
    if (height_reg < 1) return 1;
    if (height_reg > MaxH) return MaxH;
    return height_reg;
  endfunction

  function automatic void clear_frame();
    foreach (win[r, c]) win[r][c] = '0;
    pixels_seen = 0;
  endfunction

  function automatic logic [7:0] root_count(int gx, int gy);
    int s;
    int n;
    s = gx * gx + gy * gy;
    n = 0;
    for (int r = 1; r <= 255; r++) if (r * r - r < s) n++;
    return n[7:0];
  endfunction

  function automatic void sobel_predict(logic kind, logic [23:0] rgb);
    int unsigned w, h, total, n, col, k, i, j;
    logic [23:0] pix, older, newer;
    int gx, gy, v, kx, ky;
    logic [7:0] mag [3];
    edge_pixel_t e;
    w = active_width();
    h = active_height();
    total = w * h;
    n = pixels_seen;
    col = n % w;
    pix = (!kind && n < total) ? rgb : 24'd0;
    older = row_older[col];
    newer = row_newer[col];
    row_older[col] = newer;
    row_newer[col] = pix;
    for (int r = 0; r < 3; r++) begin
      win[r][0] = win[r][1];
      win[r][1] = win[r][2];
    end
    win[0][2] = older;
    win[1][2] = newer;
    win[2][2] = pix;
    pixels_seen = n + 1;
    if (n < w + 1) return;
    k = n - w - 1;
    if (k >= total) return;
    i = k / w;
    j = k % w;
    for (int ch = 0; ch < 3; ch++) begin
      gx = 0;
      gy = 0;
      for (int r = 0; r < 3; r++) begin
        if (i + r < 1 || i + r > h) continue;
        for (int c = 0; c < 3; c++) begin
          if (j + c < 1 || j + c > w) continue;
          v = (win[r][c] >> (16 - 8 * ch)) & 8'hFF;
          kx = (c - 1) * ((r == 1) ? 2 : 1);
          ky = (r - 1) * ((c == 1) ? 2 : 1);
          gx += v * kx;
          gy += v * ky;
        end
      end
      mag[ch] = root_count(gx, gy);
    end
    e.red = mag[0];
    e.green = mag[1];
    e.blue = mag[2];
    e.done = (k == total - 1);
    expected_pixels.push_back(e);
    if (e.done) clear_frame();
  endfunction

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CycleLimit) begin
      $display("FAIL sobel_edge_magnitude_rgb");
      $finish;
    end
  end

  // receiver: checks each accepted result and drives the stall pattern
  int stall_mode = 0;
  int stall_phase = 0;
  always @(posedge clk_i) begin
    edge_pixel_t e;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (expected_pixels.size() == 0) begin
        $error("unexpected result red=%0d green=%0d blue=%0d", red_out_o, green_out_o,
               blue_out_o);
        failures++;
      end else begin
        e = expected_pixels.pop_front();
        if (red_out_o !== e.red) begin
          $error("red_out expected %0d actual %0d", e.red, red_out_o);
          failures++;
        end
        if (green_out_o !== e.green) begin
          $error("green_out expected %0d actual %0d", e.green, green_out_o);
          failures++;
        end
        if (blue_out_o !== e.blue) begin
          $error("blue_out expected %0d actual %0d", e.blue, blue_out_o);
          failures++;
        end
        if (frame_done_o !== e.done) begin
          $error("frame_done expected %0d actual %0d", e.done, frame_done_o);
          failures++;
        end
      end
    end
    stall_phase = stall_phase + 1;
    if (stall_phase >= 200) begin
      stall_phase = 0;
      stall_mode = $urandom_range(3, 0);
    end
    case (stall_mode)
      0: out_stall_i <= 1'b0;
      1: out_stall_i <= ($urandom_range(9, 0) < 3);
      2: out_stall_i <= ((stall_phase % 40) < 15);
      default: out_stall_i <= ($urandom_range(9, 0) < 8);
    endcase
  end

  task automatic send_item(logic kind, logic [7:0] r, logic [7:0] g, logic [7:0] b);
    int gap;
    if (gaps_on && burst_left == 0) begin
      burst_left = $urandom_range(20, 1);
      gap = $urandom_range(6, 1);
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    if (burst_left > 0) burst_left--;
    in_valid_i <= 1'b1;
    kind_i <= kind;
    red_in_i <= r;
    green_in_i <= g;
    blue_in_i <= b;
    do @(posedge clk_i); while (in_stall_o);
    sobel_predict(kind, {r, g, b});
    items_sent++;
  endtask

  task automatic wait_idle();
    in_valid_i <= 1'b0;
    while (expected_pixels.size() != 0) @(posedge clk_i);
    repeat (10) @(posedge clk_i);
  endtask

  task automatic write_reg(logic [0:0] idx, logic [12:0] data);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_data_i <= data;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    if (idx == RegWidth) width_reg = data[10:0];
    else height_reg = data;
    clear_frame();
  endtask

  function automatic logic [7:0] chan_value();
    case ($urandom_range(3, 0))
      0: return 8'd0;
      1: return 8'd255;
      default: return 8'($urandom_range(255, 0));
    endcase
  endfunction

  task automatic send_frame(int pix_noise, int pix_drains);
    int unsigned w, h;
    w = active_width();
    h = active_height();
    for (int n = 0; n < w * h; n++)
      send_item(($urandom_range(99, 0) < pix_noise), chan_value(), chan_value(), chan_value());
    for (int n = 0; n <= w; n++)
      send_item(!($urandom_range(99, 0) < pix_drains), chan_value(), chan_value(),
                chan_value());
  endtask

  task automatic test_directed();
    logic [7:0] v;
    gaps_on = 1'b0;
    write_reg(RegWidth, 13'd3);
    write_reg(RegHeight, 13'd3);
    for (int n = 0; n < 9; n++) begin
      v = (n % 2) ? 8'd255 : 8'd0;
      if (n == 4) send_item(1'b1, 8'hFF, 8'hFF, 8'hFF);
      else send_item(1'b0, v, ~v, (n < 3) ? 8'd255 : 8'd0);
    end
    // flush with a mix of pixel and drain items past the frame end
    send_item(1'b0, 8'hAA, 8'h55, 8'hFF);
    send_item(1'b1, 8'h00, 8'h00, 8'h00);
    send_item(1'b0, 8'hFF, 8'hFF, 8'hFF);
    send_item(1'b1, 8'h55, 8'hAA, 8'h01);
    wait_idle();
    write_reg(RegWidth, 13'd1);
    write_reg(RegHeight, 13'd1);
    send_item(1'b0, 8'hFF, 8'h80, 8'h01);
    send_item(1'b1, 8'h00, 8'h00, 8'h00);
    send_item(1'b1, 8'h00, 8'h00, 8'h00);
    wait_idle();
  endtask

  task automatic test_saturation();
    gaps_on = 1'b1;
    write_reg(RegWidth, 13'd0);
    write_reg(RegHeight, 13'h1FFF);
    for (int n = 0; n < 20; n++) send_item(1'b0, chan_value(), chan_value(), chan_value());
    wait_idle();
    write_reg(RegWidth, 13'h7FF);
    write_reg(RegHeight, 13'd0);
    for (int n = 0; n < 30; n++) send_item(1'b0, chan_value(), chan_value(), chan_value());
    wait_idle();
  endtask

  task automatic test_wide_row();
    write_reg(RegWidth, 13'd1024);
    write_reg(RegHeight, 13'd2);
    for (int n = 0; n < 1060; n++)
      send_item(($urandom_range(99, 0) < 5), chan_value(), chan_value(), chan_value());
    wait_idle();
  endtask

  task automatic test_random_frames();
    int unsigned w, h, cut;
    while (items_sent < 1400) begin
      gaps_on = ($urandom_range(3, 0) != 0);
      w = ($urandom_range(9, 0) == 0) ? $urandom_range(40, 1) : $urandom_range(8, 1);
      h = ($urandom_range(9, 0) == 0) ? $urandom_range(12, 1) : $urandom_range(6, 1);
      write_reg(RegWidth, 13'(w));
      write_reg(RegHeight, 13'(h));
      if ($urandom_range(9, 0) == 0) begin
        // drop the frame partway
        cut = $urandom_range(w * h + w, 1);
        for (int n = 0; n < cut; n++)
          send_item(1'($urandom_range(1, 0)), chan_value(), chan_value(), chan_value());
      end else begin
        send_frame(8, 15);
        if ($urandom_range(2, 0) == 0) send_frame(8, 15);
      end
      wait_idle();
    end
  endtask

  initial begin
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    clear_frame();
    test_directed();
    test_saturation();
    test_wide_row();
    test_random_frames();
    wait_idle();
    repeat (20) @(posedge clk_i);
    if (failures == 0 && expected_pixels.size() == 0) begin
      $display("PASS sobel_edge_magnitude_rgb");
    end else begin
      $display("FAIL sobel_edge_magnitude_rgb");
    end
    $finish;
  end

endmodule

### sobel_edge_magnitude_rgb.f
sv/sobel_pkg.sv
sv/sobel_ctrl.sv
sv/sobel_dp.sv
sv/sobel_edge_magnitude_rgb.sv
tb/sv/tb_top.sv
